// ----- design/audio_block_trust_and_level_top_assert.svh -----
// Assertion macros shared by the level meter RTL.
`ifndef AUDIO_BLOCK_TRUST_AND_LEVEL_TOP_ASSERT_SVH
`define AUDIO_BLOCK_TRUST_AND_LEVEL_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define ABTL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define ABTL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/abtl_pkg.sv -----
// Shared widths, codes and record types of the block level meter.
`default_nettype none

package abtl_pkg;

  localparam int unsigned MAX_BLOCK      = 4096;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned MAG_W          = 16;
  localparam int unsigned COUNT_W        = 13;
  localparam int unsigned SUM_W          = 29;
  localparam int unsigned SQSUM_W        = 43;
  localparam int unsigned DCLIM_W        = 16;
  localparam int unsigned CLIPLVL_W      = 15;
  localparam int unsigned PERMILLE_W     = 10;
  localparam int unsigned REASON_W       = 2;
  localparam int unsigned PERMILLE_SCALE = 1000;
  localparam int unsigned PRODUCT_W      = 23;
  localparam int unsigned ROOT_IN_W      = 32;
  localparam int unsigned ROOT_W         = ROOT_IN_W / 2;
  localparam int unsigned STEP_W         = $clog2(SQSUM_W);
  localparam int unsigned Q_DEPTH        = 2;
  localparam int unsigned Q_PTR_W        = $clog2(Q_DEPTH);

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_DC_LIMIT      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_LEVEL    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_PERMILLE = 2'd2;

  localparam logic [DCLIM_W-1:0]    DC_LIMIT_RST      = 16'd4096;
  localparam logic [CLIPLVL_W-1:0]  CLIP_LEVEL_RST    = 15'd32700;
  localparam logic [PERMILLE_W-1:0] CLIP_PERMILLE_RST = 10'd100;

  localparam logic [REASON_W-1:0] REASON_OK   = 2'd0;
  localparam logic [REASON_W-1:0] REASON_DC   = 2'd1;
  localparam logic [REASON_W-1:0] REASON_CLIP = 2'd2;

  typedef struct packed {
    logic [DCLIM_W-1:0]    dc_limit;
    logic [CLIPLVL_W-1:0]  clip_level;
    logic [PERMILLE_W-1:0] clip_permille;
  } cfg_t;

  // Totals of one finished block, handed from the front to the back.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQSUM_W-1:0]      sqsum;
    logic [COUNT_W-1:0]      clipped;
    logic [COUNT_W-1:0]      count;
    logic [MAG_W-1:0]        peak;
  } block_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- design/abtl_intf.sv -----
// Sample and result channel interfaces of the block level meter.
`default_nettype none

interface abtl_in_if;
  import abtl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;
  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface abtl_out_if;
  import abtl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       block_valid;
  logic [REASON_W-1:0]        reject_reason;
  logic signed [MAG_W-1:0]    block_mean;
  logic [MAG_W-1:0]           rms_level;
  logic [MAG_W-1:0]           peak_level;
  logic [COUNT_W-1:0]         sample_count;
  modport source (output valid, output block_valid, output reject_reason,
                  output block_mean, output rms_level, output peak_level,
                  output sample_count, input ready);
  modport sink (input valid, input block_valid, input reject_reason,
                input block_mean, input rms_level, input peak_level,
                input sample_count, output ready);
endinterface

`default_nettype wire

// ----- design/abtl_front.sv -----
// Front end: per-sample accumulation of sum, squares, clip count and peak.
`default_nettype none

module abtl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  abtl_in_if.sink              in_ch,
  input  abtl_pkg::cfg_t       cfg,
  input  abtl_pkg::q_stat_t    q_stat,
  output logic                 push,
  output abtl_pkg::block_rec_t push_rec
);
  import abtl_pkg::*;

  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQSUM_W-1:0]       sqsum_r, sqsum_nxt;
  logic [COUNT_W-1:0]       clip_cnt_r, clip_cnt_nxt;
  logic [COUNT_W-1:0]       count_r, count_nxt;
  logic [MAG_W-1:0]         peak_r, peak_nxt;
  logic signed [SAMPLE_W:0] smp_ext;
  logic signed [SAMPLE_W:0] mag_ext;
  logic [MAG_W-1:0]         mag;
  logic [2*MAG_W-1:0]       square;
  logic                     is_clip;
  logic                     accept;
  logic                     close;

  // Samples are held only while the queue is full, so they stream otherwise.
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    smp_ext      = {in_ch.sample[SAMPLE_W-1], in_ch.sample};
    mag_ext      = smp_ext[SAMPLE_W] ? -smp_ext : smp_ext;
    mag          = mag_ext[MAG_W-1:0];
    square       = mag * mag;
    is_clip      = mag >= {1'b0, cfg.clip_level};
    sum_nxt      = sum_r + SUM_W'(smp_ext);
    sqsum_nxt    = sqsum_r + SQSUM_W'(square);
    clip_cnt_nxt = clip_cnt_r + COUNT_W'(is_clip);
    peak_nxt     = (mag > peak_r) ? mag : peak_r;
    count_nxt    = count_r + COUNT_W'(1);
    close        = in_ch.last_sample || (count_nxt == COUNT_W'(MAX_BLOCK));
  end

  assign push              = accept && close;
  assign push_rec.sum      = sum_nxt;
  assign push_rec.sqsum    = sqsum_nxt;
  assign push_rec.clipped  = clip_cnt_nxt;
  assign push_rec.count    = count_nxt;
  assign push_rec.peak     = peak_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && close)) begin
      sum_r      <= '0;
      sqsum_r    <= '0;
      clip_cnt_r <= '0;
      count_r    <= '0;
      peak_r     <= '0;
    end else if (accept) begin
      sum_r      <= sum_nxt;
      sqsum_r    <= sqsum_nxt;
      clip_cnt_r <= clip_cnt_nxt;
      count_r    <= count_nxt;
      peak_r     <= peak_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/abtl_queue.sv -----
// Short queue of finished block records between the front and the back.
`default_nettype none

module abtl_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  abtl_pkg::block_rec_t push_rec,
  input  logic                 pop,
  output abtl_pkg::block_rec_t pop_rec,
  output abtl_pkg::q_stat_t    q_stat
);
  import abtl_pkg::*;

  block_rec_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   fill_r;

  assign q_stat.full  = fill_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign q_stat.empty = fill_r == '0;
  assign pop_rec      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // The depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + (Q_PTR_W+1)'(1);
        2'b01:   fill_r <= fill_r - (Q_PTR_W+1)'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/abtl_back.sv -----
// Back end: bit-serial divisions, square root, trust checks and result register.
`default_nettype none

module abtl_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  abtl_pkg::cfg_t       cfg,
  input  abtl_pkg::q_stat_t    q_stat,
  output logic                 pop,
  input  abtl_pkg::block_rec_t pop_rec,
  abtl_out_if.source           out_ch
);
  import abtl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_DC,
    ST_DIV_MS,
    ST_SQRT,
    ST_DONE
  } state_t;

  state_t                  state_r;
  block_rec_t              rec_r;
  logic [SQSUM_W-1:0]      quo_r;
  logic [COUNT_W:0]        rem_r;
  logic [STEP_W-1:0]       step_r;
  logic [MAG_W-1:0]        dc_mag_r;
  logic [ROOT_IN_W-1:0]    rad_r;
  logic [ROOT_W-1:0]       root_r;
  logic [ROOT_W+2:0]       srem_r;

  logic                    out_valid_r;
  logic                    block_valid_r;
  logic [REASON_W-1:0]     reason_r;
  logic [MAG_W-1:0]        dc_r;
  logic [MAG_W-1:0]        rms_r;
  logic [MAG_W-1:0]        peak_r;
  logic [COUNT_W-1:0]      count_out_r;

  logic signed [SUM_W-1:0] sum_abs;
  logic [COUNT_W:0]        rem_sh;
  logic                    div_fits;
  logic [COUNT_W:0]        rem_step;
  logic [SQSUM_W-1:0]      quo_step;
  logic [ROOT_W+2:0]       srem_sh;
  logic [ROOT_W+2:0]       trial;
  logic                    sq_fits;
  logic [ROOT_W+2:0]       srem_step;
  logic [ROOT_W-1:0]       root_step;
  logic                    dc_reject;
  logic                    clip_reject;
  logic [PRODUCT_W-1:0]    clip_lhs;
  logic [PRODUCT_W-1:0]    clip_rhs;
  logic [MAG_W-1:0]        dc_signed;
  logic                    out_free;

  assign pop      = (state_r == ST_IDLE) && !q_stat.empty;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    sum_abs   = pop_rec.sum[SUM_W-1] ? -pop_rec.sum : pop_rec.sum;

    // One restoring division step: the dividend shifts out of quo_r at the top.
    rem_sh    = {rem_r[COUNT_W-1:0], quo_r[SQSUM_W-1]};
    div_fits  = rem_sh >= {1'b0, rec_r.count};
    rem_step  = div_fits ? rem_sh - {1'b0, rec_r.count} : rem_sh;
    quo_step  = {quo_r[SQSUM_W-2:0], div_fits};

    // One square root step on the next two radicand bits.
    srem_sh   = {srem_r[ROOT_W:0], rad_r[ROOT_IN_W-1 -: 2]};
    trial     = {1'b0, root_r, 2'b01};
    sq_fits   = srem_sh >= trial;
    srem_step = sq_fits ? srem_sh - trial : srem_sh;
    root_step = {root_r[ROOT_W-2:0], sq_fits};

    dc_signed   = rec_r.sum[SUM_W-1] ? -dc_mag_r : dc_mag_r;
    dc_reject   = dc_mag_r > cfg.dc_limit;
    clip_lhs    = PRODUCT_W'(rec_r.clipped) * PRODUCT_W'(PERMILLE_SCALE);
    clip_rhs    = PRODUCT_W'(cfg.clip_permille) * PRODUCT_W'(rec_r.count);
    clip_reject = clip_lhs > clip_rhs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // In ST_DONE the result register is loaded below whenever it is free.
      if (out_valid_r && out_ch.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            rec_r   <= pop_rec;
            quo_r   <= SQSUM_W'(unsigned'(sum_abs));
            rem_r   <= '0;
            step_r  <= STEP_W'(SQSUM_W - 1);
            state_r <= ST_DIV_DC;
          end
        end
        ST_DIV_DC: begin
          if (step_r == '0) begin
            dc_mag_r <= quo_step[MAG_W-1:0];
            quo_r    <= rec_r.sqsum;
            rem_r    <= '0;
            step_r   <= STEP_W'(SQSUM_W - 1);
            state_r  <= ST_DIV_MS;
          end else begin
            quo_r  <= quo_step;
            rem_r  <= rem_step;
            step_r <= step_r - STEP_W'(1);
          end
        end
        ST_DIV_MS: begin
          if (step_r == '0) begin
            // The mean square never exceeds full scale squared.
            rad_r   <= quo_step[ROOT_IN_W-1:0];
            root_r  <= '0;
            srem_r  <= '0;
            step_r  <= STEP_W'(ROOT_W - 1);
            state_r <= ST_SQRT;
          end else begin
            quo_r  <= quo_step;
            rem_r  <= rem_step;
            step_r <= step_r - STEP_W'(1);
          end
        end
        ST_SQRT: begin
          rad_r  <= rad_r << 2;
          root_r <= root_step;
          srem_r <= srem_step;
          step_r <= step_r - STEP_W'(1);
          if (step_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            dc_r          <= dc_signed;
            count_out_r   <= rec_r.count;
            block_valid_r <= 1'b0;
            rms_r         <= '0;
            peak_r        <= '0;
            if (dc_reject) begin
              reason_r <= REASON_DC;
            end else if (clip_reject) begin
              reason_r <= REASON_CLIP;
            end else begin
              reason_r      <= REASON_OK;
              block_valid_r <= 1'b1;
              rms_r         <= root_r;
              peak_r        <= rec_r.peak;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.block_valid   = block_valid_r;
  assign out_ch.reject_reason = reason_r;
  assign out_ch.block_mean    = dc_r;
  assign out_ch.rms_level     = rms_r;
  assign out_ch.peak_level    = peak_r;
  assign out_ch.sample_count  = count_out_r;

endmodule

`default_nettype wire

// ----- design/audio_block_trust_and_level_top.sv -----
// Samples stream in at one per cycle while the queue has room; a block's totals are queued when it closes.
// After a block's totals are taken from the queue, the back end runs 43 + 43
// divider steps (mean and mean square) and 16 square root steps before the result.
// Short blocks can close faster than that back end sequence; the queue then fills and holds the input.
// Synchronous active-low reset clears the accumulators, the queue and the result
// valid flag and restores the register defaults; no clearing pass is needed.
`default_nettype none

`include "audio_block_trust_and_level_top_assert.svh"

module audio_block_trust_and_level_top (
  input  logic                              clk,
  input  logic                              rst_n,
  abtl_in_if.sink                           in_ch,
  abtl_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [abtl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [abtl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import abtl_pkg::*;

  cfg_t       cfg_r;
  q_stat_t    q_stat;
  logic       push;
  block_rec_t push_rec;
  logic       pop;
  block_rec_t pop_rec;

  // Writes to an index past the last register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dc_limit      <= DC_LIMIT_RST;
      cfg_r.clip_level    <= CLIP_LEVEL_RST;
      cfg_r.clip_permille <= CLIP_PERMILLE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DC_LIMIT:      cfg_r.dc_limit      <= cfg_wdata[DCLIM_W-1:0];
        REG_CLIP_LEVEL:    cfg_r.clip_level    <= cfg_wdata[CLIPLVL_W-1:0];
        REG_CLIP_PERMILLE: cfg_r.clip_permille <= cfg_wdata[PERMILLE_W-1:0];
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  abtl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  abtl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .q_stat   (q_stat)
  );

  abtl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_stat  (q_stat),
    .pop     (pop),
    .pop_rec (pop_rec),
    .out_ch  (out_ch)
  );

  `ABTL_ASSERT_IMP(a_full_stalls_input, q_stat.full, !in_ch.ready, "sample accepted while queue is full")
  `ABTL_ASSERT_IMP(a_valid_matches_reason, out_ch.valid, out_ch.block_valid == (out_ch.reject_reason == REASON_OK), "block_valid disagrees with reject_reason")
  `ABTL_ASSERT_IMP(a_rejected_levels_zero, out_ch.valid && !out_ch.block_valid, out_ch.rms_level == '0 && out_ch.peak_level == '0, "rejected block reports nonzero levels")
  `ABTL_ASSERT_NXT(a_dc_limit_write, cfg_we && cfg_addr == REG_DC_LIMIT, cfg_r.dc_limit == $past(cfg_wdata), "dc_limit write lost")

endmodule

`default_nettype wire

// ----- tb/audio_block_trust_and_level_top_tb.sv -----
// Self-checking testbench for the audio block level meter with trust checks.
module audio_block_trust_and_level_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import abtl_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 950;
  localparam int RUN_LIMIT_NS = 2_000_000;

  typedef enum {STY_QUIET, STY_FULL, STY_NEAR_CLIP, STY_BIASED, STY_EXTREME} block_style_t;

  typedef struct {
    logic                    block_valid;
    logic [REASON_W-1:0]     reject_reason;
    logic signed [MAG_W-1:0] block_mean;
    logic [MAG_W-1:0]        rms_level;
    logic [MAG_W-1:0]        peak_level;
    logic [COUNT_W-1:0]      sample_count;
  } level_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  abtl_in_if  in_ch();
  abtl_out_if out_ch();

  audio_block_trust_and_level_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies as the meter should hold them.
  logic [DCLIM_W-1:0]    dc_limit_q = DC_LIMIT_RST;
  logic [CLIPLVL_W-1:0]  clip_level_q = CLIP_LEVEL_RST;
  logic [PERMILLE_W-1:0] permille_q = CLIP_PERMILLE_RST;

  // Totals of the block that is being collected.
  longint          blk_sum = 0;
  longint unsigned blk_sqsum = 0;
  int unsigned     blk_clipped = 0;
  int unsigned     blk_count = 0;
  int unsigned     blk_peak = 0;

  level_result_t expected_levels[$];
  int            block_buf[$];
  int            mismatch_count = 0;
  bit            idle_on = 1'b1;
  bit            stall_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 21; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Adds one transferred sample to the block totals and closes the block
  // on the last-sample flag or when it reaches the size bound.
  task automatic absorb_sample(int s, bit last);
    int unsigned     mag;
    longint          dc;
    longint unsigned dc_mag;
    level_result_t   r;
    mag = (s < 0) ? -s : s;
    blk_sum += s;
    blk_sqsum += longint'(mag) * mag;
    if (mag >= clip_level_q) blk_clipped++;
    if (mag > blk_peak) blk_peak = mag;
    blk_count++;
    if (!last && blk_count < MAX_BLOCK) return;

    dc = blk_sum / longint'(blk_count);
    dc_mag = (dc < 0) ? -dc : dc;
    r.block_valid = 1'b0;
    r.reject_reason = REASON_OK;
    r.rms_level = '0;
    r.peak_level = '0;
    if (dc_mag > dc_limit_q) begin
      r.reject_reason = REASON_DC;
    end else if (longint'(blk_clipped) * PERMILLE_SCALE > longint'(permille_q) * blk_count) begin
      r.reject_reason = REASON_CLIP;
    end else begin
      r.block_valid = 1'b1;
      r.rms_level = 16'(floor_root(blk_sqsum / blk_count));
      r.peak_level = 16'(blk_peak);
    end
    r.block_mean = 16'(dc);
    r.sample_count = 13'(blk_count);
    expected_levels.push_back(r);

    blk_sum = 0;
    blk_sqsum = 0;
    blk_clipped = 0;
    blk_count = 0;
    blk_peak = 0;
  endtask

  task automatic send_sample(int s, bit last);
    int gap;
    gap = pick_gap(idle_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= 16'(s);
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    absorb_sample(s, last);
  endtask

  task automatic send_block(bit close_with_last);
    foreach (block_buf[i]) begin
      send_sample(block_buf[i], close_with_last && i == block_buf.size() - 1);
    end
    block_buf.delete();
  endtask

  // Holds off the sender until every block result is back and the back end
  // has had time to settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DC_LIMIT:      dc_limit_q = val;
      REG_CLIP_LEVEL:    clip_level_q = val[CLIPLVL_W-1:0];
      REG_CLIP_PERMILLE: permille_q = val[PERMILLE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_levels(logic [15:0] dc, logic [15:0] clip, logic [15:0] permille);
    wait_idle();
    write_reg(REG_DC_LIMIT, dc);
    write_reg(REG_CLIP_LEVEL, clip);
    write_reg(REG_CLIP_PERMILLE, permille);
  endtask

  task automatic send_random_block(int len, block_style_t style);
    int base;
    int amp;
    int v;
    base = 0;
    amp = 0;
    case (style)
      STY_QUIET: begin
        base = $urandom_range(0, 1000) - 500;
        amp = $urandom_range(1, 3000);
      end
      STY_BIASED: begin
        base = $urandom_range(2000, 32000);
        if ($urandom_range(0, 1) == 1) base = -base;
        amp = $urandom_range(0, 3000);
      end
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      case (style)
        STY_FULL: v = $signed(16'($urandom));
        STY_NEAR_CLIP: begin
          if ($urandom_range(0, 1) == 1) v = int'(clip_level_q) + $urandom_range(0, 4) - 2;
          else v = $urandom_range(0, 200) - 100;
          if ($urandom_range(0, 1) == 1) v = -v;
        end
        STY_EXTREME: begin
          case ($urandom_range(0, 4))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            3: v = -1;
            default: v = 1;
          endcase
        end
        default: v = base + $urandom_range(0, 2 * amp) - amp;
      endcase
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      send_sample(v, i == len - 1);
    end
  endtask

  task automatic test_reset_defaults();
    block_buf = {0};
    send_block(1'b1);
    block_buf = {32767};
    send_block(1'b1);
    block_buf = {-32768};
    send_block(1'b1);
    // Zero mean but every sample is clipped.
    block_buf = {32767, -32767};
    send_block(1'b1);
    block_buf = {1000, -1000, 500, -1};
    send_block(1'b1);
  endtask

  task automatic test_dc_check();
    set_levels(16'd100, 16'd32700, 16'd100);
    // Means of 100.5 and -101.5 truncate to 100 and -101.
    block_buf = {201, 0};
    send_block(1'b1);
    block_buf = {-203, 0};
    send_block(1'b1);
  endtask

  task automatic test_clip_check();
    set_levels(16'd4096, 16'd1000, 16'd250);
    block_buf = {1000, 0, -999, 0};
    send_block(1'b1);
    block_buf = {-1000, 1000, 0, 0};
    send_block(1'b1);
  endtask

  task automatic test_zero_clip_level();
    set_levels(16'd4096, 16'd0, 16'd1000);
    block_buf = {0, 5};
    send_block(1'b1);
    set_levels(16'd4096, 16'd0, 16'd999);
    block_buf = {0};
    send_block(1'b1);
  endtask

  task automatic test_register_extremes();
    // All-ones writes land as 32767 and 1023 after the field widths cut them.
    set_levels(16'd0, 16'hFFFF, 16'd0);
    block_buf = {3, -3};
    send_block(1'b1);
    wait_idle();
    write_reg(REG_UNUSED, 16'hFFFF);
    block_buf = {1};
    send_block(1'b1);
    set_levels(16'hFFFF, 16'hFFFF, 16'hFFFF);
    block_buf = {32767};
    send_block(1'b1);
  endtask

  task automatic test_block_bound();
    set_levels(16'd32768, 16'd32767, 16'd1000);
    idle_on = 1'b0;
    repeat (MAX_BLOCK) block_buf.push_back(-32768);
    send_block(1'b0);
    block_buf = {7};
    send_block(1'b1);
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int sent;
    int len;
    logic [15:0] dc_val;
    logic [15:0] clip_val;
    logic [15:0] permille_val;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0: dc_val = 16'd0;
        1: dc_val = 16'd32768;
        2: dc_val = 16'hFFFF;
        3: dc_val = 16'($urandom_range(0, 32768));
        default: dc_val = DC_LIMIT_RST;
      endcase
      case ($urandom_range(0, 5))
        0: clip_val = 16'd0;
        1: clip_val = 16'd32767;
        2: clip_val = 16'($urandom);
        default: clip_val = 16'($urandom_range(16000, 32767));
      endcase
      case ($urandom_range(0, 4))
        0: permille_val = 16'd0;
        1: permille_val = 16'd1000;
        2: permille_val = 16'd1023;
        3: permille_val = 16'($urandom_range(0, 1000));
        default: permille_val = 16'($urandom_range(50, 500));
      endcase
      set_levels(dc_val, clip_val, permille_val);
      idle_on = ($urandom_range(0, 4) != 0);
      stall_on = ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(2, 6)) begin
        len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 32) : $urandom_range(33, 200);
        send_random_block(len, block_style_t'($urandom_range(0, 4)));
        sent += len;
      end
    end
    idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_levels
    level_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_levels.size() == 0) begin
        $error("result transfer with no block outstanding");
        mismatch_count++;
      end else begin
        want = expected_levels.pop_front();
        check_field("block_valid", want.block_valid, out_ch.block_valid);
        check_field("reject_reason", want.reject_reason, out_ch.reject_reason);
        check_field("block_mean", want.block_mean, out_ch.block_mean);
        check_field("rms_level", want.rms_level, out_ch.rms_level);
        check_field("peak_level", want.peak_level, out_ch.peak_level);
        check_field("sample_count", want.sample_count, out_ch.sample_count);
      end
    end
  end

  // Result side back-pressure: short runs of ready broken by random stalls.
  initial begin
    int stall;
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap(stall_on);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_DC_LIMIT;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.last_sample <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_dc_check();
    test_clip_check();
    test_zero_clip_level();
    test_register_extremes();
    test_block_bound();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0 && expected_levels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
